### hw/rtl/wmcr_pkg.sv
// Package for the min/max waveform column reducer.
// Sizes, register indexes, controller/datapath structs and the curve ROM.
// No dependencies.
`default_nettype none

package wmcr_pkg;

   localparam int COLUMN_BITS     = 12;
   localparam int COUNT_BITS      = 20;
   localparam int CURVE_FRAC_BITS = 16;
   localparam int CURVE_BITS      = CURVE_FRAC_BITS + 1;
   localparam int MAX_RESULTS     = 64;
   localparam int RESULT_CNT_BITS = $clog2(MAX_RESULTS + 1);
   localparam int WIDTH_BITS      = COLUMN_BITS + 1;
   localparam int NUM_BITS        = COUNT_BITS + COLUMN_BITS + 1;
   localparam int HEIGHT_BITS     = 12;
   localparam int CSR_DATA_BITS   = 20;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_COLUMNS  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_HEIGHT   = 2'd2;

   typedef logic signed [7:0] sample_type;
   typedef logic [127:0][CURVE_BITS-1:0] curve_rom_type;

   typedef struct packed {
      logic accept;
      logic rom_load;
      logic mult_load;
      logic advance;
      logic emit;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic item_ok;
      logic cont_now;
      logic cont_next;
      logic count_full;
      logic out_free;
   } dp_status_type;

   function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] prod;
      prod = a * b;
      return prod >> 30;
   endfunction

   function automatic logic [63:0] q30_mul_round(input logic [63:0] a,
                                                 input logic [63:0] b);
      logic [63:0] prod;
      prod = a * b + (64'd1 << 29);
      return prod >> 30;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bits;
      v    = v_in;
      res  = 64'd0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 64'd0) begin
         if (v >= res + bits) begin
            v   = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] pow5_q30(input logic [63:0] y);
      logic [63:0] y2;
      y2 = q30_mul(y, y);
      return q30_mul(q30_mul(y2, y2), y);
   endfunction

   // (a/127)^0.65 = ((a/127)^(1/20))^13, rounded to Q1.CURVE_FRAC_BITS
   function automatic curve_rom_type build_curve();
      curve_rom_type rom;
      logic [63:0]   r;
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic [63:0]   mid;
      logic [63:0]   s;
      logic [63:0]   p;
      for (int a = 0; a < 128; a++) begin
         r  = ((64'(a) << 30) + 64'd63) / 127;
         lo = 64'd0;
         hi = 64'd1 << 30;
         while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 2;
            if (pow5_q30(mid) <= r) lo = mid;
            else hi = mid - 64'd1;
         end
         s = int_sqrt(int_sqrt(lo << 30) << 30);
         p = s;
         for (int k = 0; k < 12; k++) p = q30_mul_round(p, s);
         p = (p + (64'd1 << (29 - CURVE_FRAC_BITS))) >> (30 - CURVE_FRAC_BITS);
         if (p > (64'd1 << CURVE_FRAC_BITS)) p = 64'd1 << CURVE_FRAC_BITS;
         rom[a] = p[CURVE_BITS-1:0];
      end
      return rom;
   endfunction

   localparam curve_rom_type CURVE_ROM = build_curve();

endpackage

`default_nettype wire

### hw/rtl/wmcr_req_if.sv
// Input channel: one envelope column word (min/max pair) with valid/ready.
// Depends on wmcr_pkg.
`default_nettype none

interface wmcr_req_if;
   import wmcr_pkg::*;

   logic       valid;
   logic       ready;
   sample_type min_sample;
   sample_type max_sample;

   modport source (output valid, output min_sample, output max_sample, input ready);
   modport sink   (input valid, input min_sample, input max_sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/wmcr_rsp_if.sv
// Result channel: one vertical segment word with valid/ready.
// Depends on wmcr_pkg.
`default_nettype none

interface wmcr_rsp_if;
   import wmcr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [COLUMN_BITS-1:0] column;
   logic [HEIGHT_BITS-1:0] top_row;
   logic [HEIGHT_BITS:0]   bottom_row;
   logic                   last;

   modport source (output valid, output column, output top_row, output bottom_row,
                   output last, input ready);
   modport sink   (input valid, input column, input top_row, input bottom_row,
                   input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/waveform_minmax_column_reducer_core.sv
// Min/max waveform column reducer, top level.
// Instantiates wmcr_ctrl and wmcr_datapath; uses wmcr_pkg, wmcr_req_if, wmcr_rsp_if.
//
// Usage:
//   req_chan carries one stored envelope column word (min_sample, max_sample).
//   rsp_chan carries vertical segment words (column, top_row, bottom_row, last);
//   last marks the final segment caused by one input word.
//   csr_* writes base_columns (0), display_width (1), half_height (2);
//   writing 0 or 1 restarts the frame. Write only while idle.
// Timing:
//   An input word is taken in the idle state. Curve lookup and multiply
//   follow in the ROM and MULT states; then one segment word is loaded per
//   cycle into the output register while it is free, and a closing step ends
//   the word. Columns beyond 64 per word are skipped with no segment.
//   Words past the end of the frame, or with N or W zero, are taken and
//   dropped in the same cycle.
// Reset: synchronous; config returns to N = 1, W = 1, half height 0.
// Stall: a segment waits in the output register; the next segment waits for
//   it, and the next input word may be taken while the last one is held.
`default_nettype none

module waveform_minmax_column_reducer_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   wmcr_req_if.sink                                 req_chan,
   wmcr_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [wmcr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [wmcr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import wmcr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   wmcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wmcr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_min     (req_chan.min_sample),
      .in_max     (req_chan.max_sample),
      .cmd        (cmd),
      .status     (status),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_column (rsp_chan.column),
      .out_top    (rsp_chan.top_row),
      .out_bottom (rsp_chan.bottom_row),
      .out_last   (rsp_chan.last)
   );

endmodule

`default_nettype wire

### hw/rtl/wmcr_ctrl.sv
// Controller FSM of the column reducer: sequences accept, curve lookup,
// multiply and segment emission. Depends on wmcr_pkg.
`default_nettype none

module wmcr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire wmcr_pkg::dp_status_type status,
   output wmcr_pkg::ctrl_cmd_type      cmd
);
   import wmcr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROM  = 2'd1;
   localparam logic [1:0] ST_MULT = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && status.item_ok) begin
               cmd.accept = 1'b1;
               state_in   = ST_ROM;
            end
         end
         ST_ROM: begin
            cmd.rom_load = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult_load = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.cont_now) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.count_full) begin
               cmd.advance = 1'b1;
            end else if (status.out_free) begin
               cmd.advance = 1'b1;
               cmd.emit    = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

### hw/rtl/wmcr_datapath.sv
// Datapath of the column reducer: config registers, running min/max, column
// boundary tracking, curve ROM and multiply, output register. Depends on wmcr_pkg.
`default_nettype none

module wmcr_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [wmcr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [wmcr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire wmcr_pkg::sample_type                in_min,
   input  wire wmcr_pkg::sample_type                in_max,
   input  wire wmcr_pkg::ctrl_cmd_type              cmd,
   output wmcr_pkg::dp_status_type                  status,
   input  wire logic                                out_ready,
   output logic                                     out_valid,
   output logic [wmcr_pkg::COLUMN_BITS-1:0]         out_column,
   output logic [wmcr_pkg::HEIGHT_BITS-1:0]         out_top,
   output logic [wmcr_pkg::HEIGHT_BITS:0]           out_bottom,
   output logic                                     out_last
);
   import wmcr_pkg::*;

   localparam logic [WIDTH_BITS-1:0] W_CAP = WIDTH_BITS'(1) << COLUMN_BITS;

   logic [COUNT_BITS-1:0]      n_ff, n_in;
   logic [WIDTH_BITS-1:0]      w_raw_ff, w_raw_in;
   logic [HEIGHT_BITS-1:0]     hh_ff, hh_in;
   logic [WIDTH_BITS-1:0]      w_eff, w_new_eff;
   logic                       restart;

   sample_type                 rmin_ff, rmin_in;
   sample_type                 rmax_ff, rmax_in;
   logic                       open_ff, open_in;
   logic                       closed_ff, closed_in;
   logic [COUNT_BITS-1:0]      j_ff, j_in;
   logic [WIDTH_BITS-1:0]      di_ff, di_in;
   logic [NUM_BITS-1:0]        num_ff, num_in;
   logic [NUM_BITS-1:0]        p_ff, p_in;
   logic [RESULT_CNT_BITS-1:0] cnt_ff, cnt_in;

   logic [CURVE_BITS-1:0]      rom_hi_ff, rom_lo_ff;
   logic [6:0]                 amp_hi, amp_lo;
   logic [CURVE_BITS+HEIGHT_BITS-1:0] prod_hi, prod_lo;
   logic [HEIGHT_BITS-1:0]     h_hi, h_lo;
   logic [HEIGHT_BITS-1:0]     top_ff;
   logic [HEIGHT_BITS:0]       bot_ff;

   logic                       valid_ff, valid_in;
   logic [COLUMN_BITS-1:0]     col_ff;
   logic [HEIGHT_BITS-1:0]     otop_ff;
   logic [HEIGHT_BITS:0]       obot_ff;
   logic                       last_ff;

   logic [NUM_BITS-1:0]        num_next;
   logic [NUM_BITS-1:0]        p_plus_w;
   logic                       more_left;
   logic                       brk_now, brk_next;

   assign w_eff = (w_raw_ff > W_CAP) ? W_CAP : w_raw_ff;
   assign restart = csr_wr_en &&
                    (csr_index == CSR_BASE_COLUMNS || csr_index == CSR_DISPLAY_WIDTH);

   always_comb begin
      n_in      = n_ff;
      w_raw_in  = w_raw_ff;
      hh_in     = hh_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_COLUMNS:  n_in     = csr_wdata[COUNT_BITS-1:0];
            CSR_DISPLAY_WIDTH: w_raw_in = csr_wdata[WIDTH_BITS-1:0];
            CSR_HALF_HEIGHT:   hh_in    = csr_wdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
      w_new_eff = (w_raw_in > W_CAP) ? W_CAP : w_raw_in;
   end

   // segment x closes on item j when min(max(floor(num/w), start+1), n) <= j+1,
   // with num = (x+1)*n and p = (j+1)*w
   assign num_next  = num_ff + NUM_BITS'(n_ff);
   assign p_plus_w  = p_ff + NUM_BITS'(w_eff);
   assign more_left = {1'b0, n_ff} > ({1'b0, j_ff} + (COUNT_BITS+1)'(1));
   assign brk_now   = more_left &&
                      (num_ff >= p_plus_w || (num_ff - NUM_BITS'(n_ff)) >= p_ff);
   assign brk_next  = more_left &&
                      (num_next >= p_plus_w || (num_next - NUM_BITS'(n_ff)) >= p_ff);

   always_comb begin
      status.item_ok    = (n_ff != '0) && (w_eff != '0) && (j_ff < n_ff);
      status.cont_now   = (di_ff < w_eff) && !brk_now;
      status.cont_next  = ((di_ff + WIDTH_BITS'(1)) < w_eff) && !brk_next;
      status.count_full = (cnt_ff == RESULT_CNT_BITS'(MAX_RESULTS));
      status.out_free   = !valid_ff || out_ready;
   end

   always_comb begin
      rmin_in   = rmin_ff;
      rmax_in   = rmax_ff;
      open_in   = open_ff;
      closed_in = closed_ff;
      j_in      = j_ff;
      di_in     = di_ff;
      num_in    = num_ff;
      p_in      = p_ff;
      cnt_in    = cnt_ff;
      if (restart) begin
         rmin_in = '0;
         rmax_in = '0;
         open_in = 1'b0;
         j_in    = '0;
         di_in   = '0;
         num_in  = NUM_BITS'(n_in);
         p_in    = NUM_BITS'(w_new_eff);
      end else begin
         if (cmd.accept) begin
            if (!open_ff) begin
               rmin_in = in_min;
               rmax_in = in_max;
            end else begin
               if (in_min < rmin_ff) rmin_in = in_min;
               if (in_max > rmax_ff) rmax_in = in_max;
            end
            open_in   = 1'b1;
            closed_in = 1'b0;
            cnt_in    = '0;
         end
         if (cmd.advance) begin
            di_in     = di_ff + WIDTH_BITS'(1);
            num_in    = num_next;
            closed_in = 1'b1;
            if (cmd.emit) cnt_in = cnt_ff + RESULT_CNT_BITS'(1);
         end
         if (cmd.finish) begin
            j_in = j_ff + COUNT_BITS'(1);
            p_in = p_plus_w;
            if (closed_ff) open_in = 1'b0;
         end
      end
   end

   // curve amplitudes: negative max counts as zero, |-128| counts as 127
   always_comb begin
      amp_hi = rmax_ff[7] ? 7'd0 : rmax_ff[6:0];
      if (rmin_ff[7]) amp_lo = (rmin_ff == -8'sd128) ? 7'd127 : 7'(-rmin_ff);
      else amp_lo = rmin_ff[6:0];
   end

   assign prod_hi = rom_hi_ff * hh_ff;
   assign prod_lo = rom_lo_ff * hh_ff;
   assign h_hi    = prod_hi[CURVE_FRAC_BITS +: HEIGHT_BITS];
   assign h_lo    = prod_lo[CURVE_FRAC_BITS +: HEIGHT_BITS];

   assign valid_in = cmd.emit ? 1'b1 : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= COUNT_BITS'(1);
         w_raw_ff  <= WIDTH_BITS'(1);
         hh_ff     <= '0;
         rmin_ff   <= '0;
         rmax_ff   <= '0;
         open_ff   <= 1'b0;
         closed_ff <= 1'b0;
         j_ff      <= '0;
         di_ff     <= '0;
         num_ff    <= NUM_BITS'(1);
         p_ff      <= NUM_BITS'(1);
         cnt_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         n_ff      <= n_in;
         w_raw_ff  <= w_raw_in;
         hh_ff     <= hh_in;
         rmin_ff   <= rmin_in;
         rmax_ff   <= rmax_in;
         open_ff   <= open_in;
         closed_ff <= closed_in;
         j_ff      <= j_in;
         di_ff     <= di_in;
         num_ff    <= num_in;
         p_ff      <= p_in;
         cnt_ff    <= cnt_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rom_load) begin
         rom_hi_ff <= CURVE_ROM[amp_hi];
         rom_lo_ff <= CURVE_ROM[amp_lo];
      end
      if (cmd.mult_load) begin
         top_ff <= hh_ff - h_hi;
         bot_ff <= {1'b0, hh_ff} + {1'b0, h_lo};
      end
      if (cmd.emit) begin
         col_ff  <= di_ff[COLUMN_BITS-1:0];
         otop_ff <= top_ff;
         obot_ff <= bot_ff;
         last_ff <= (cnt_ff == RESULT_CNT_BITS'(MAX_RESULTS - 1)) || !status.cont_next;
      end
   end

   assign out_valid  = valid_ff;
   assign out_column = col_ff;
   assign out_top    = otop_ff;
   assign out_bottom = obot_ff;
   assign out_last   = last_ff;

endmodule

`default_nettype wire
